/* rtl/mmc_command_line_engine_macros.svh */
// Assertion macros for the MMC command line engine.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef MMC_COMMAND_LINE_ENGINE_MACROS_SVH
`define MMC_COMMAND_LINE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define MMCLE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check that an expression is never true outside reset.
`define MMCLE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define MMCLE_ASSERT(label, clk, rst_n, prop, msg)
`define MMCLE_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/mmcle_pkg.sv */
// Types, constants and CRC7 helpers of the MMC command line engine.
// No dependencies; the interface and module files import it.
package mmcle_pkg;

	localparam int HEADER_BITS = 40;
	localparam int FRAME_BITS  = 48;
	localparam int CRC_W       = 7;
	localparam int RESP_W      = 38;
	localparam int CNT_W       = 8;
	localparam int CFG_W       = 8;
	localparam int IDX_W       = 6;
	localparam int ARG_W       = 32;

	localparam logic [CRC_W-1:0] CRC_POLY = 7'h09;

	// Configuration register indexes and reset values
	localparam logic REG_GAP_CLOCKS       = 1'b0;
	localparam logic REG_RESPONSE_TIMEOUT = 1'b1;
	localparam logic [CFG_W-1:0] GAP_CLOCKS_RESET       = 8'd24;
	localparam logic [CFG_W-1:0] RESPONSE_TIMEOUT_RESET = 8'd200;

	// Operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] command_index;
		logic [ARG_W-1:0] argument;
		logic             want_response;
		logic             cmd_sample;
	} in_item_t;

	typedef struct packed {
		logic              drive_enable;
		logic              drive_level;
		logic              busy_res;
		logic              done_res;
		logic              status;
		logic [RESP_W-1:0] response;
	} out_item_t;

	// Word held in the input stage: frame already built and CRC appended
	typedef struct packed {
		logic                  operation;
		logic                  want_response;
		logic                  cmd_sample;
		logic [FRAME_BITS-1:0] frame;
	} stage_t;

	// Bit-serial CRC7, MSB first, from zero; evaluated at elaboration only
	function automatic logic [CRC_W-1:0] crc7_serial(input logic [HEADER_BITS-1:0] h);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = '0;
		for (int k = HEADER_BITS - 1; k >= 0; k--) begin
			fb = h[k] ^ c[CRC_W-1];
			c = {c[CRC_W-2:0], 1'b0};
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// Per CRC bit, the set of header bits that feed it
	function automatic logic [CRC_W-1:0][HEADER_BITS-1:0] crc7_masks();
		logic [CRC_W-1:0][HEADER_BITS-1:0] m;
		logic [HEADER_BITS-1:0]            unit;
		logic [CRC_W-1:0]                  c;
		m = '0;
		for (int k = 0; k < HEADER_BITS; k++) begin
			unit = '0;
			unit[k] = 1'b1;
			c = crc7_serial(unit);
			for (int j = 0; j < CRC_W; j++) m[j][k] = c[j];
		end
		return m;
	endfunction

	localparam logic [CRC_W-1:0][HEADER_BITS-1:0] CRC7_MASKS = crc7_masks();

	// CRC7 as one XOR tree per bit
	function automatic logic [CRC_W-1:0] crc7_parallel(input logic [HEADER_BITS-1:0] h);
		logic [CRC_W-1:0] c;
		for (int j = 0; j < CRC_W; j++) c[j] = ^(h & CRC7_MASKS[j]);
		return c;
	endfunction

endpackage

/* rtl/mmcle_if.sv */
// Valid/ready channels of the MMC command line engine.
// Depends on mmcle_pkg for the item and result word types.
interface mmcle_in_if;
	import mmcle_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mmcle_out_if;
	import mmcle_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/mmcle_frame.sv */
// Input stage: takes an item word, builds the 48-bit command frame with CRC7.
// Depends on mmcle_pkg and mmcle_in_if.
module mmcle_frame (
	input  logic             clk,
	input  logic             arst_n,
	mmcle_in_if.sink         item,
	input  logic             advance,
	output logic             valid_s1,
	output mmcle_pkg::stage_t stage_s1
);
	import mmcle_pkg::*;

	logic [HEADER_BITS-1:0] header;
	logic [CRC_W-1:0]       crc;
	logic                   take;

	// Accept when the stage is empty or drains this cycle
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	// Build header: start bit 0, transmission bit 1, index, argument
	assign header = {2'b01, item.data.command_index, item.data.argument};
	assign crc    = crc7_parallel(header);

	// Hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Capture word
	always_ff @(posedge clk) begin
		if (take) begin
			stage_s1.operation     <= item.data.operation;
			stage_s1.want_response <= item.data.want_response;
			stage_s1.cmd_sample    <= item.data.cmd_sample;
			stage_s1.frame         <= {header, crc, 1'b1};
		end
	end

endmodule

/* rtl/mmcle_core.sv */
// Command sequencer: gap, frame transmit, response wait and capture,
// with configuration registers and result register.
// Depends on mmcle_pkg, mmcle_out_if and the assertion macro header.
`include "mmc_command_line_engine_macros.svh"

module mmcle_core #(
	parameter int unsigned RESPONSE_BITS = 38
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write_enable,
	input  logic              reg_index,
	input  logic [mmcle_pkg::CFG_W-1:0] write_data,
	input  logic              valid_s1,
	input  mmcle_pkg::stage_t stage_s1,
	output logic              advance,
	mmcle_out_if.source       result
);
	import mmcle_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_GAP  = 3'd1;
	localparam logic [2:0] PH_SEND = 3'd2;
	localparam logic [2:0] PH_WAIT = 3'd3;
	localparam logic [2:0] PH_RECV = 3'd4;

	logic [CFG_W-1:0]      gap_clocks_q;
	logic [CFG_W-1:0]      timeout_q;
	logic [2:0]            phase_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [RESP_W-1:0]     resp_q;
	logic                  want_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [2:0]            ph_n;
	logic [CNT_W-1:0]      cnt_n;
	logic [FRAME_BITS-1:0] frame_n;
	logic [RESP_W-1:0]     resp_n;
	logic                  want_n;
	out_item_t             res_n;

	// Advance when the result register is free or being taken
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_clocks_q <= GAP_CLOCKS_RESET;
			timeout_q    <= RESPONSE_TIMEOUT_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_GAP_CLOCKS:       gap_clocks_q <= write_data;
				REG_RESPONSE_TIMEOUT: timeout_q    <= write_data;
				default:              ;
			endcase
		end
	end

	// Step one bus clock period
	always_comb begin
		ph_n    = phase_q;
		cnt_n   = cnt_q;
		frame_n = frame_q;
		resp_n  = resp_q;
		want_n  = want_q;
		res_n   = '0;

		// Start only from idle; a start while busy runs as a tick
		if (phase_q == PH_IDLE && stage_s1.operation == OP_START) begin
			frame_n = stage_s1.frame;
			want_n  = stage_s1.want_response;
			resp_n  = '0;
			cnt_n   = '0;
			ph_n    = PH_GAP;
		end

		// Count gap periods, fall into the first frame bit when done
		if (ph_n == PH_GAP) begin
			if (cnt_n < gap_clocks_q) begin
				cnt_n = cnt_n + 1'b1;
			end else begin
				ph_n  = PH_SEND;
				cnt_n = '0;
			end
		end

		unique case (ph_n)
			PH_SEND: begin
				res_n.drive_enable = 1'b1;
				res_n.drive_level  = frame_n[FRAME_BITS-1];
				frame_n = {frame_n[FRAME_BITS-2:0], 1'b0};
				cnt_n   = cnt_n + 1'b1;
				if (cnt_n >= CNT_W'(FRAME_BITS)) begin
					ph_n  = PH_WAIT;
					cnt_n = '0;
				end
			end
			PH_WAIT: begin
				if (!stage_s1.cmd_sample) begin
					cnt_n = '0;
					if (want_n) begin
						ph_n = PH_RECV;
					end else begin
						ph_n           = PH_IDLE;
						res_n.done_res = 1'b1;
					end
				end else begin
					cnt_n = cnt_n + 1'b1;
					if (cnt_n >= timeout_q) begin
						ph_n           = PH_IDLE;
						cnt_n          = '0;
						res_n.done_res = 1'b1;
						res_n.status   = 1'b1;
					end
				end
			end
			PH_RECV: begin
				resp_n = {resp_n[RESP_W-2:0], stage_s1.cmd_sample};
				cnt_n  = cnt_n + 1'b1;
				if (cnt_n >= CNT_W'(RESPONSE_BITS)) begin
					ph_n           = PH_IDLE;
					cnt_n          = '0;
					res_n.done_res = 1'b1;
					res_n.response = resp_n;
				end
			end
			default: ;
		endcase

		res_n.busy_res = (ph_n != PH_IDLE);
	end

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			want_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= ph_n;
			cnt_q   <= cnt_n;
			want_q  <= want_n;
		end
	end

	// Shift registers
	always_ff @(posedge clk) begin
		if (advance) begin
			frame_q <= frame_n;
			resp_q  <= resp_n;
		end
	end

	// Result valid: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		if (advance) out_q <= res_n;
	end

	`MMCLE_ASSERT(a_idle_cnt_clear, clk, arst_n, (phase_q == PH_IDLE) |-> (cnt_q == '0), "counter not clear in idle")
	`MMCLE_ASSERT(a_level_needs_drive, clk, arst_n, (out_valid_q && out_q.drive_level) |-> out_q.drive_enable, "level driven while undriven")
	`MMCLE_ASSERT_NEVER(a_done_busy, clk, arst_n, out_valid_q && out_q.done_res && out_q.busy_res, "done and busy together")
	`MMCLE_ASSERT(a_status_with_done, clk, arst_n, (out_valid_q && out_q.status) |-> out_q.done_res, "status without done")
	`MMCLE_ASSERT(a_hold_when_stalled, clk, arst_n, (!advance && !valid_s1) |=> $stable(phase_q), "phase moved without an item")

endmodule

/* rtl/mmc_command_line_engine.sv */
// Usage:
// Host side of an eMMC CMD line. Each item on the "item" channel stands for one
// bus clock period and carries the sampled CMD level; operation set to start
// latches command index, argument and response request (ignored while busy).
// Each item gives exactly one word on the "result" channel: drive enable and
// level for that period, busy, done, timeout status and captured response.
// The frame (0, 1, index, argument, CRC7, 1) goes out after gap_clocks
// undriven periods; the engine then waits up to response_timeout periods for
// a low start bit and, if asked, shifts in RESPONSE_BITS bits.
// Configuration: write_enable with reg_index (0 gap_clocks, 1 response_timeout)
// and write_data; write only while no command is in progress.
// Path: the CRC7 tree feeds the input register, and the sequencer step then
// feeds the result register, from which the receiver takes the result.
// Throughput: one item per clock while the result receiver takes every word.
// A stalled result receiver holds the result register and backs up the input
// register; no word is lost or repeated. Reset (arst_n low) empties both
// registers, sets the engine idle and restores the register defaults.
// Depends on mmcle_pkg, mmcle_if, mmcle_frame and mmcle_core.
module mmc_command_line_engine #(
	parameter int unsigned RESPONSE_BITS = 38
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_enable,
	input  logic                        reg_index,
	input  logic [mmcle_pkg::CFG_W-1:0] write_data,
	mmcle_in_if.sink                    item,
	mmcle_out_if.source                 result
);
	import mmcle_pkg::*;

	logic   valid_s1;
	logic   advance;
	stage_t stage_s1;

	// Input register and frame build
	mmcle_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1)
	);

	// Sequencer and result register
	mmcle_core #(
		.RESPONSE_BITS (RESPONSE_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.valid_s1     (valid_s1),
		.stage_s1     (stage_s1),
		.advance      (advance),
		.result       (result)
	);

endmodule
